@@ hdl/q2r_pkg.sv @@
package q2r_pkg;

  localparam int unsigned DataWidthDef = 16;
  localparam int unsigned NumEntries   = 9;
  localparam int unsigned NumComps     = 4;
  localparam int unsigned NarrowMax    = 31;

endpackage

@@ hdl/q2r_div.sv @@
module q2r_div import q2r_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned DEN_WIDTH  = 2 * DATA_WIDTH + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [DEN_WIDTH-1:0]  mag_i [NumEntries],
  input  logic [NumEntries-1:0] neg_i,
  input  logic [DEN_WIDTH-1:0]  den_i,
  input  logic                  zero_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [DATA_WIDTH-1:0] quot_o [NumEntries],
  output logic [NumEntries-1:0] neg_o,
  output logic                  zero_o
);

  localparam int unsigned Frac   = DATA_WIDTH - 2;
  localparam int unsigned QW     = DATA_WIDTH;
  localparam int unsigned Stages = Frac + 2;

  logic                  v_q    [Stages];
  logic [DEN_WIDTH-1:0]  mag_q  [Stages][NumEntries];
  logic [QW-1:0]         quo_q  [Stages][NumEntries];
  logic [NumEntries-1:0] sgn_q  [Stages];
  logic [DEN_WIDTH-1:0]  den_q  [Stages];
  logic                  zero_q [Stages];
  logic [Stages:0]       en;

  assign en[Stages] = ready_i;
  assign ready_o    = en[0];

  for (genvar k = 0; k < Stages; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  // first step: integer part of the ratio, clamped
  logic [DEN_WIDTH-1:0]  mag0_d [NumEntries];
  logic [QW-1:0]         quo0_d [NumEntries];

  always_comb begin
    logic ge1;
    logic ge2;
    for (int e = 0; e < NumEntries; e++) begin
      ge1 = mag_i[e] >= den_i;
      ge2 = {1'b0, mag_i[e]} >= {den_i, 1'b0};
      if (ge2) begin
        mag0_d[e] = den_i - DEN_WIDTH'(1);
      end else if (ge1) begin
        mag0_d[e] = mag_i[e] - den_i;
      end else begin
        mag0_d[e] = mag_i[e];
      end
      quo0_d[e] = QW'(ge1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_q[0]  <= mag0_d;
      quo_q[0]  <= quo0_d;
      sgn_q[0]  <= neg_i;
      den_q[0]  <= den_i;
      zero_q[0] <= zero_i;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k < Stages; k++) begin : g_step
    logic [DEN_WIDTH:0]    rem   [NumEntries];
    logic [NumEntries-1:0] ge;
    logic [DEN_WIDTH-1:0]  mag_d [NumEntries];
    logic [QW-1:0]         quo_d [NumEntries];

    always_comb begin
      for (int e = 0; e < NumEntries; e++) begin
        rem[e] = {mag_q[k-1][e], 1'b0};
        ge[e]  = rem[e] >= {1'b0, den_q[k-1]};
        if (ge[e]) begin
          mag_d[e] = DEN_WIDTH'(rem[e] - {1'b0, den_q[k-1]});
        end else begin
          mag_d[e] = DEN_WIDTH'(rem[e]);
        end
        quo_d[e] = {quo_q[k-1][e][QW-2:0], ge[e]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        mag_q[k]  <= mag_d;
        quo_q[k]  <= quo_d;
        sgn_q[k]  <= sgn_q[k-1];
        den_q[k]  <= den_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign quot_o  = quo_q[Stages-1];
  assign neg_o   = sgn_q[Stages-1];
  assign zero_o  = zero_q[Stages-1];

endmodule

@@ hdl/quaternion_to_rotation_matrix.sv @@
// channel  | direction | tdata (lowest bits first)                     | tuser
// s_axis   | in        | quat_real, quat_i, quat_j, quat_k (W each)    | -
// m_axis   | out       | m00 m01 m02 m10 m11 m12 m20 m21 m22 (W each)  | zero_norm_error
//
// one transaction per cycle sustained while m_axis_tready stays high
// most of the pipeline depth is in the restoring divider: one quotient bit per stage, nine lanes
// reset clears only the valid bits of every stage
// a stage holds while the next one is full and stalled; empty stages close up,
// so input is taken while a finished matrix waits at the output register
module quaternion_to_rotation_matrix import q2r_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // quat_real, quat_i, quat_j, quat_k
  input  logic [((NumComps*DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [((NumEntries*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // zero_norm_error
  output logic [0:0] m_axis_tuser
);

  localparam int unsigned Frac = DATA_WIDTH - 2;
  localparam int unsigned NW   = (DATA_WIDTH > NarrowMax) ? NarrowMax : DATA_WIDTH;
  localparam int unsigned PW   = 2 * NW;
  localparam int unsigned DW   = PW + 1;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned NumProds = 10;

  localparam int unsigned CW = 0;
  localparam int unsigned CX = 1;
  localparam int unsigned CY = 2;
  localparam int unsigned CZ = 3;

  localparam int unsigned PWW = 0;
  localparam int unsigned PXX = 1;
  localparam int unsigned PYY = 2;
  localparam int unsigned PZZ = 3;
  localparam int unsigned PXY = 4;
  localparam int unsigned PXZ = 5;
  localparam int unsigned PYZ = 6;
  localparam int unsigned PXW = 7;
  localparam int unsigned PYW = 8;
  localparam int unsigned PZW = 9;

  localparam logic signed [DATA_WIDTH-1:0] PosLim = DATA_WIDTH'(1) << Frac;
  localparam logic signed [DATA_WIDTH-1:0] NegLim = -PosLim;

  logic en_a, en_b, en_c, en_d, en_e;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  // stage a: narrowed components
  logic signed [NW-1:0] qa_q [NumComps];
  // stage b: products
  logic signed [PW-1:0] pb_q [NumProds];
  // stage c: norm and numerators
  logic        [DW-1:0] nc_q;
  logic signed [SW-1:0] num_c_q [NumEntries];
  logic signed [SW-1:0] num_c_d [NumEntries];
  // stage d: magnitudes and signs
  logic [DW-1:0]         mag_d_q [NumEntries];
  logic [NumEntries-1:0] neg_d_q;
  logic [DW-1:0]         den_d_q;
  logic                  zero_d_q;
  // divider output
  logic                  div_ready;
  logic                  div_valid;
  logic [DATA_WIDTH-1:0] div_quot [NumEntries];
  logic [NumEntries-1:0] div_neg;
  logic                  div_zero;
  // stage e: output register
  logic signed [DATA_WIDTH-1:0] me_q [NumEntries];
  logic signed [DATA_WIDTH-1:0] me_d [NumEntries];
  logic                         ze_q;
  logic                         range_ok;

  assign en_e = ~ve_q | m_axis_tready;
  assign en_d = ~vd_q | div_ready;
  assign en_c = ~vc_q | en_d;
  assign en_b = ~vb_q | en_c;
  assign en_a = ~va_q | en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_a) begin
        va_q <= s_axis_tvalid;
      end
      if (en_b) begin
        vb_q <= va_q;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
      if (en_d) begin
        vd_q <= vc_q;
      end
      if (en_e) begin
        ve_q <= div_valid;
      end
    end
  end

  // floor shift for the widest words is the top bits of each component
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int c = 0; c < NumComps; c++) begin
        qa_q[c] <= s_axis_tdata[c*DATA_WIDTH + DATA_WIDTH - NW +: NW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      pb_q[PWW] <= qa_q[CW] * qa_q[CW];
      pb_q[PXX] <= qa_q[CX] * qa_q[CX];
      pb_q[PYY] <= qa_q[CY] * qa_q[CY];
      pb_q[PZZ] <= qa_q[CZ] * qa_q[CZ];
      pb_q[PXY] <= qa_q[CX] * qa_q[CY];
      pb_q[PXZ] <= qa_q[CX] * qa_q[CZ];
      pb_q[PYZ] <= qa_q[CY] * qa_q[CZ];
      pb_q[PXW] <= qa_q[CX] * qa_q[CW];
      pb_q[PYW] <= qa_q[CY] * qa_q[CW];
      pb_q[PZW] <= qa_q[CZ] * qa_q[CW];
    end
  end

  always_comb begin
    num_c_d[0] = SW'(pb_q[PWW]) + SW'(pb_q[PXX]) - SW'(pb_q[PYY]) - SW'(pb_q[PZZ]);
    num_c_d[1] = (SW'(pb_q[PXY]) - SW'(pb_q[PZW])) <<< 1;
    num_c_d[2] = (SW'(pb_q[PXZ]) + SW'(pb_q[PYW])) <<< 1;
    num_c_d[3] = (SW'(pb_q[PXY]) + SW'(pb_q[PZW])) <<< 1;
    num_c_d[4] = SW'(pb_q[PWW]) - SW'(pb_q[PXX]) + SW'(pb_q[PYY]) - SW'(pb_q[PZZ]);
    num_c_d[5] = (SW'(pb_q[PYZ]) - SW'(pb_q[PXW])) <<< 1;
    num_c_d[6] = (SW'(pb_q[PXZ]) - SW'(pb_q[PYW])) <<< 1;
    num_c_d[7] = (SW'(pb_q[PYZ]) + SW'(pb_q[PXW])) <<< 1;
    num_c_d[8] = SW'(pb_q[PWW]) - SW'(pb_q[PXX]) - SW'(pb_q[PYY]) + SW'(pb_q[PZZ]);
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      nc_q    <= DW'(pb_q[PWW]) + DW'(pb_q[PXX]) + DW'(pb_q[PYY]) + DW'(pb_q[PZZ]);
      num_c_q <= num_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      for (int e = 0; e < NumEntries; e++) begin
        neg_d_q[e] <= num_c_q[e][SW-1];
        mag_d_q[e] <= num_c_q[e][SW-1] ? DW'(-num_c_q[e]) : DW'(num_c_q[e]);
      end
      den_d_q  <= nc_q;
      zero_d_q <= (nc_q == '0);
    end
  end

  q2r_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEN_WIDTH  (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q),
    .ready_o (div_ready),
    .mag_i   (mag_d_q),
    .neg_i   (neg_d_q),
    .den_i   (den_d_q),
    .zero_i  (zero_d_q),
    .valid_o (div_valid),
    .ready_i (en_e),
    .quot_o  (div_quot),
    .neg_o   (div_neg),
    .zero_o  (div_zero)
  );

  // round half away from zero, clamp, restore sign
  always_comb begin
    logic [DATA_WIDTH:0]   inc;
    logic [DATA_WIDTH-1:0] mag;
    for (int e = 0; e < NumEntries; e++) begin
      inc = {1'b0, div_quot[e]} + (DATA_WIDTH+1)'(1);
      mag = inc[DATA_WIDTH:1];
      if (mag > PosLim) begin
        mag = PosLim;
      end
      if (div_zero) begin
        me_d[e] = '0;
      end else if (div_neg[e]) begin
        me_d[e] = -mag;
      end else begin
        me_d[e] = mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      me_q <= me_d;
      ze_q <= div_zero;
    end
  end

  assign m_axis_tvalid   = ve_q;
  assign m_axis_tuser[0] = ze_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int e = 0; e < NumEntries; e++) begin
      m_axis_tdata[e*DATA_WIDTH +: DATA_WIDTH] = me_q[e];
    end
  end

  always_comb begin
    range_ok = 1'b1;
    for (int e = 0; e < NumEntries; e++) begin
      if (me_q[e] > PosLim || me_q[e] < NegLim) begin
        range_ok = 1'b0;
      end
    end
  end

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("zero norm with non-zero entries");

  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> range_ok)
    else $error("entry outside unit range");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && !en_e |=> div_valid)
    else $error("divider dropped a stalled result");

  a_front_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !va_q |-> s_axis_tready)
    else $error("input stalled with empty first stage");

endmodule
